[hdl/bce_pkg.sv]
// Package for the clamped binary cross-entropy core.
// Holds field widths, fixed-point constants and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bce_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GUARD_BITS = FRAC_BITS + 4;
	localparam int PRED_W = 17;
	localparam int N_W = 16;
	localparam int WGT_W = 24;
	localparam int FLR_W = 16;
	localparam int DEN_W = N_W + PRED_W;
	localparam int DVD_W = 41;
	localparam int GRAD_W = 40;
	localparam int LOSS_W = 36;
	localparam int SUM_W = 40;
	localparam int NLN_W = 20;
	localparam int L2_W = 25;
	localparam int MANT_W = 31;
	localparam int LN_SHIFT = GUARD_BITS + 30 - FRAC_BITS;

	localparam logic [PRED_W-1:0] ONE_Q = PRED_W'(1) << FRAC_BITS;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	localparam logic [1:0] CFG_SAMPLES = 2'd0;
	localparam logic [1:0] CFG_WEIGHT = 2'd1;
	localparam logic [1:0] CFG_FLOOR = 2'd2;

endpackage

[hdl/bce_div.sv]
// Restoring divider, one quotient bit per cycle, shared by gradient and mean loss.
// Depends on bce_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module bce_div
	import bce_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEPS = DVD_W;
	localparam int CNT_W = $clog2(STEPS);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dsr_q;
	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dsr_q};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

[hdl/bce_log.sv]
// Negative natural log of x / 2^16 by repeated squaring of the mantissa.
// One multiplier is reused for each squaring step and the final ln2 scale.
// Depends on bce_pkg for widths and the ln2 constant.
`timescale 1ns / 1ps

module bce_log
	import bce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PRED_W-1:0] x,
	output logic              done,
	output logic [NLN_W-1:0]  neg_ln
);

	typedef enum logic [3:0] {
		L_IDLE  = 4'b0001,
		L_SQ    = 4'b0010,
		L_SCALE = 4'b0100,
		L_ROUND = 4'b1000
	} lstate_t;

	localparam int CNT_W = $clog2(GUARD_BITS);
	localparam int PROD_W = 2 * MANT_W;
	localparam int SCL_W = L2_W + 30;

	lstate_t            state_q;
	logic [4:0]         k_q;
	logic [MANT_W-1:0]  m_q;
	logic [GUARD_BITS-1:0] frac_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SCL_W-1:0]   prod_q;
	logic [NLN_W-1:0]   nl_q;
	logic               done_q;

	logic [4:0]         k;
	logic [MANT_W-1:0]  m_init;
	logic [L2_W-1:0]    l2;
	logic [MANT_W-1:0]  mul_a;
	logic [MANT_W-1:0]  mul_b;
	logic [PROD_W-1:0]  prod;
	logic [31:0]        sq;
	logic [SCL_W:0]     rnd;

	// leading one position
	always_comb begin
		k = '0;
		for (int i = 0; i < PRED_W; i++) begin
			if (x[i]) k = 5'(i);
		end
	end

	assign m_init = MANT_W'(x) << (5'd30 - k);
	assign l2 = {5'(FRAC_BITS) - k_q, GUARD_BITS'(0)} - L2_W'(frac_q);

	always_comb begin
		if (state_q == L_SQ) begin
			mul_a = m_q;
			mul_b = m_q;
		end else begin
			mul_a = MANT_W'(l2);
			mul_b = MANT_W'(LN2_Q30);
		end
	end

	assign prod = mul_a * mul_b;
	assign sq = prod[61:30];
	assign rnd = {1'b0, prod_q} + ((SCL_W+1)'(1) << (LN_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_SQ;
						cnt_q <= '0;
					end
				end
				L_SQ: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(GUARD_BITS - 1)) state_q <= L_SCALE;
				end
				L_SCALE: state_q <= L_ROUND;
				L_ROUND: begin
					state_q <= L_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			k_q <= k;
			m_q <= m_init;
			frac_q <= '0;
		end
		if (state_q == L_SQ) begin
			// mantissa squared in Q1.30; a carry into 2.0 yields a fraction bit
			m_q <= sq[31] ? sq[31:1] : sq[30:0];
			frac_q <= {frac_q[GUARD_BITS-2:0], sq[31]};
		end
		if (state_q == L_SCALE) prod_q <= prod[SCL_W-1:0];
		if (state_q == L_ROUND) nl_q <= rnd[LN_SHIFT+NLN_W-1:LN_SHIFT];
	end

	assign done = done_q;
	assign neg_ln = nl_q;

endmodule

[hdl/clamped_binary_cross_entropy_core.sv]
// Clamped binary cross-entropy core: gradient and running loss per item.
// Depends on bce_pkg, bce_div (shared divider) and bce_log (log unit).
//
//  channel  | dir | payload
//  s_axis   | in  | tdata[16:0] prediction, [17] label_bit; tlast final_element
//  m_axis   | out | tdata[39:0] gradient, [75:40] batch_loss; tlast loss_valid
//  cfg      | in  | cfg_index register, cfg_data value (always ready)
//
// One item at a time. A plain item runs the 41-step divider for the gradient,
// with the log unit beside it. A final item adds a second 41-step pass of the
// same divider for the mean.
// The result sits in an output register, so a new item is taken while it waits.
// Asynchronous active-low reset clears control state and loads register defaults.
`timescale 1ns / 1ps

module clamped_binary_cross_entropy_core
	import bce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [16:0] prediction, [17] label_bit
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [39:0] gradient, [75:40] batch_loss
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PREP   = 8'b0000_0010,
		S_GSTART = 8'b0000_0100,
		S_WAIT   = 8'b0000_1000,
		S_ACC    = 8'b0001_0000,
		S_LSTART = 8'b0010_0000,
		S_LWAIT  = 8'b0100_0000,
		S_WRITE  = 8'b1000_0000
	} state_t;

	localparam logic [DVD_W-1:0] POS_MAX = DVD_W'(40'h7F_FFFF_FFFF);
	localparam logic [DVD_W-1:0] NEG_MAG = DVD_W'(40'h80_0000_0000);

	state_t             state_q;
	logic [N_W-1:0]     n_q;
	logic [WGT_W-1:0]   w_q;
	logic [FLR_W-1:0]   floor_q;
	logic [PRED_W-1:0]  q_q;
	logic               pos_q;
	logic               fin_q;
	logic [DEN_W-1:0]   den_q;
	logic [GRAD_W-1:0]  grad_q;
	logic [LOSS_W-1:0]  batch_q;
	logic [SUM_W-1:0]   loss_sum_q;
	logic               gd_q;
	logic               ld_q;
	logic               out_valid_q;
	logic [GRAD_W-1:0]  out_grad_q;
	logic [LOSS_W-1:0]  out_loss_q;
	logic               out_last_q;

	logic [N_W-1:0]     n_eff;
	logic [FLR_W-1:0]   floor_eff;
	logic [PRED_W-1:0]  p_in;
	logic [PRED_W-1:0]  q_sel;
	logic [PRED_W-1:0]  q_in;
	logic               in_fire;
	logic               out_load;
	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DEN_W-1:0]   div_dsr;
	logic               div_done;
	logic [DVD_W-1:0]   div_quo;
	logic               log_done;
	logic [NLN_W-1:0]   log_val;
	logic [DVD_W-1:0]   mag;
	logic [SUM_W:0]     sum;

	assign n_eff = (n_q == '0) ? N_W'(1) : n_q;
	assign floor_eff = (floor_q == '0) ? FLR_W'(1) : floor_q;

	// clamp p to 1.0, pick p or 1-p by label, then raise to the floor
	assign p_in = (s_axis_tdata[16:0] > ONE_Q) ? ONE_Q : s_axis_tdata[16:0];
	assign q_sel = s_axis_tdata[17] ? p_in : ONE_Q - p_in;
	assign q_in = (q_sel < PRED_W'(floor_eff)) ? PRED_W'(floor_eff) : q_sel;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == S_WRITE) && (!out_valid_q || m_axis_tready);
	assign cfg_ready = 1'b1;

	assign div_start = (state_q == S_GSTART) || (state_q == S_LSTART);
	always_comb begin
		if (state_q == S_LSTART) begin
			div_dvd = DVD_W'(loss_sum_q) + DVD_W'(n_eff[N_W-1:1]);
			div_dsr = DEN_W'(n_eff);
		end else begin
			div_dvd = {1'b0, w_q, FRAC_BITS'(0)} + DVD_W'(den_q[DEN_W-1:1]);
			div_dsr = den_q;
		end
	end

	bce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	bce_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_PREP),
		.x      (q_q),
		.done   (log_done),
		.neg_ln (log_val)
	);

	always_comb begin
		if (pos_q) mag = (div_quo > NEG_MAG) ? NEG_MAG : div_quo;
		else mag = (div_quo > POS_MAX) ? POS_MAX : div_quo;
	end

	assign sum = {1'b0, loss_sum_q} + (SUM_W+1)'(log_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= N_W'(1);
			w_q <= WGT_W'(65536);
			floor_q <= FLR_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SAMPLES: n_q <= cfg_data[N_W-1:0];
				CFG_WEIGHT:  w_q <= cfg_data[WGT_W-1:0];
				CFG_FLOOR:   floor_q <= cfg_data[FLR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loss_sum_q <= '0;
			gd_q <= 1'b0;
			ld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_PREP;
				S_PREP: begin
					gd_q <= 1'b0;
					ld_q <= 1'b0;
					state_q <= S_GSTART;
				end
				S_GSTART: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) gd_q <= 1'b1;
					if (log_done) ld_q <= 1'b1;
					if (gd_q && ld_q) state_q <= S_ACC;
				end
				S_ACC: begin
					loss_sum_q <= sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
					state_q <= fin_q ? S_LSTART : S_WRITE;
				end
				S_LSTART: state_q <= S_LWAIT;
				S_LWAIT: begin
					if (div_done) begin
						loss_sum_q <= '0;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			q_q <= q_in;
			pos_q <= s_axis_tdata[17];
			fin_q <= s_axis_tlast;
		end
		if (state_q == S_PREP) begin
			den_q <= n_eff * q_q;
			batch_q <= '0;
		end
		if (state_q == S_WAIT && div_done) begin
			grad_q <= pos_q ? -mag[GRAD_W-1:0] : mag[GRAD_W-1:0];
		end
		if (state_q == S_LWAIT && div_done) begin
			batch_q <= (div_quo[DVD_W-1:LOSS_W] != '0) ? {LOSS_W{1'b1}}
				: div_quo[LOSS_W-1:0];
		end
		if (out_load) begin
			out_grad_q <= grad_q;
			out_loss_q <= batch_q;
			out_last_q <= fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0, out_loss_q, out_grad_q};
	assign m_axis_tlast = out_last_q;

endmodule

[tb/clamped_binary_cross_entropy_core_tb.sv]
// Self-checking testbench for clamped_binary_cross_entropy_core.
// Predicts gradient and batch loss per item in fixed point and compares every result.
// Depends on bce_pkg and the core RTL.
`timescale 1ns / 1ps

module clamped_binary_cross_entropy_core_tb;
	import bce_pkg::*;

	localparam logic [63:0] GRAD_POS_MAX = (64'd1 << (GRAD_W - 1)) - 64'd1;
	localparam logic [63:0] GRAD_NEG_MAG = 64'd1 << (GRAD_W - 1);
	localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] LOSS_MAX = (64'd1 << LOSS_W) - 64'd1;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [GRAD_W-1:0] gradient;
		logic [LOSS_W-1:0]        batch_loss;
		logic                     loss_valid;
	} bce_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [16:0] prediction, [17] label_bit
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // [39:0] gradient, [75:40] batch_loss
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	// shadow copy of the core's registers and accumulator
	logic [N_W-1:0]   cur_samples = N_W'(1);
	logic [WGT_W-1:0] cur_weight = WGT_W'(65536);
	logic [FLR_W-1:0] cur_floor = FLR_W'(7);
	logic [63:0]      loss_total = 64'd0;

	bce_result_t grad_loss_q[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int rx_hold_req = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;

	clamped_binary_cross_entropy_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// -ln(x / 2^F) in Q.F, x in [1, 2^F]: log2 by squaring the mantissa, then times ln2
	function automatic logic [63:0] neg_ln_fixed(input logic [63:0] x);
		int k;
		int i;
		logic [63:0] t;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] l2;
		k = 0;
		t = x;
		while (t > 64'd1) begin
			t = t >> 1;
			k++;
		end
		m = x << (30 - k);
		frac = 64'd0;
		for (i = 0; i < GUARD_BITS; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		l2 = (64'(FRAC_BITS - k) << GUARD_BITS) - frac;
		return (l2 * 64'(LN2_Q30) + (64'd1 << (LN_SHIFT - 1))) >> LN_SHIFT;
	endfunction

	// expected result of one item; updates the shadow accumulator
	function automatic bce_result_t compute_grad_and_loss(input logic [PRED_W-1:0] pred,
			input logic lbl, input logic fin);
		logic [63:0] one;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] n;
		logic [63:0] flr;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] mag;
		logic [63:0] mean;
		bce_result_t r;
		one = 64'd1 << FRAC_BITS;
		p = 64'(pred);
		if (p > one)
			p = one;
		n = (cur_samples == '0) ? 64'd1 : 64'(cur_samples);
		flr = (cur_floor == '0) ? 64'd1 : 64'(cur_floor);
		q = lbl ? p : one - p;
		if (q < flr)
			q = flr;
		num = 64'(cur_weight) << FRAC_BITS;
		den = n * q;
		mag = (num + den / 64'd2) / den;
		if (lbl) begin
			if (mag > GRAD_NEG_MAG)
				mag = GRAD_NEG_MAG;
			r.gradient = GRAD_W'(64'd0 - mag);
		end else begin
			if (mag > GRAD_POS_MAX)
				mag = GRAD_POS_MAX;
			r.gradient = GRAD_W'(mag);
		end
		loss_total = loss_total + neg_ln_fixed(q);
		if (loss_total > SUM_MAX)
			loss_total = SUM_MAX;
		if (fin) begin
			mean = (loss_total + n / 64'd2) / n;
			if (mean > LOSS_MAX)
				mean = LOSS_MAX;
			r.batch_loss = LOSS_W'(mean);
			r.loss_valid = 1'b1;
			loss_total = 64'd0;
		end else begin
			r.batch_loss = '0;
			r.loss_valid = 1'b0;
		end
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_item(input logic [PRED_W-1:0] pred, input logic lbl, input logic fin);
		int gap;
		gap = tx_gaps_on ? int'($urandom_range(0, 12)) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, lbl, pred};
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		grad_loss_q.push_back(compute_grad_and_loss(pred, lbl, fin));
	endtask

	task automatic stop_and_drain();
		s_axis_tvalid <= 1'b0;
		while (grad_loss_q.size() != 0)
			@(posedge clk);
	endtask

	// only called with the core idle
	task automatic write_regs(input logic [N_W-1:0] samples, input logic [WGT_W-1:0] weight,
			input logic [FLR_W-1:0] flr);
		int i;
		for (i = 0; i < 3; i++) begin
			case (i)
				0: begin
					cfg_index <= CFG_SAMPLES;
					cfg_data <= 24'(samples);
				end
				1: begin
					cfg_index <= CFG_WEIGHT;
					cfg_data <= weight;
				end
				default: begin
					cfg_index <= CFG_FLOOR;
					cfg_data <= 24'(flr);
				end
			endcase
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_samples = samples;
		cur_weight = weight;
		cur_floor = flr;
	endtask

	function automatic logic [PRED_W-1:0] rand_prediction();
		case ($urandom_range(0, 9))
			0: return PRED_W'($urandom_range(0, 15));
			1: return PRED_W'(65536 - $urandom_range(0, 15));
			2: return PRED_W'($urandom_range(65537, 131071));
			default: return PRED_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [N_W-1:0] rand_samples();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return N_W'(1);
			2: return N_W'(65535);
			3: return N_W'($urandom_range(2, 16));
			default: return N_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WGT_W'(65536);
			2: return WGT_W'(24'hFFFFFF);
			3: return WGT_W'($urandom_range(1, 24'h3FFFF));
			default: return WGT_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	function automatic logic [FLR_W-1:0] rand_floor();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return FLR_W'(1);
			2: return FLR_W'(7);
			3: return FLR_W'(65535);
			4: return FLR_W'($urandom_range(1, 64));
			default: return FLR_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic test_directed();
		// reset defaults: clamp, saturated p, both labels
		send_item(PRED_W'(0), 1'b1, 1'b0);
		send_item(PRED_W'(0), 1'b0, 1'b0);
		send_item(PRED_W'(65536), 1'b1, 1'b0);
		send_item(PRED_W'(65536), 1'b0, 1'b0);
		send_item(PRED_W'(17'h1FFFF), 1'b1, 1'b0);
		send_item(PRED_W'(17'h1FFFF), 1'b0, 1'b0);
		send_item(PRED_W'(65537), 1'b0, 1'b0);
		send_item(PRED_W'(32768), 1'b1, 1'b1);
		send_item(PRED_W'(3), 1'b1, 1'b1);
		stop_and_drain();
		// zero count and zero floor taken as 1; max weight saturates the gradient
		write_regs('0, WGT_W'(24'hFFFFFF), '0);
		send_item(PRED_W'(0), 1'b1, 1'b0);
		send_item(PRED_W'(65536), 1'b0, 1'b0);
		send_item(PRED_W'(1), 1'b1, 1'b1);
		send_item(PRED_W'(17'h15555), 1'b0, 1'b1);
		stop_and_drain();
		write_regs(N_W'(65535), '0, FLR_W'(65535));
		send_item(PRED_W'(65536), 1'b1, 1'b0);
		send_item(PRED_W'(12345), 1'b0, 1'b0);
		send_item(PRED_W'(0), 1'b1, 1'b1);
		stop_and_drain();
		write_regs(N_W'(3), WGT_W'(1), FLR_W'(1));
		send_item(PRED_W'(17'h0AAAA), 1'b1, 1'b0);
		send_item(PRED_W'(17'h05555), 1'b0, 1'b1);
		stop_and_drain();
	endtask

	// output held off for a long stretch while input keeps coming
	task automatic test_backpressure();
		int i;
		write_regs(N_W'(5), WGT_W'(65536), FLR_W'(7));
		tx_gaps_on = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		for (i = 0; i < 20; i++)
			send_item(rand_prediction(), 1'($urandom_range(0, 1)), (i % 5) == 4);
		stop_and_drain();
		tx_gaps_on = 1'b1;
	endtask

	// one long batch of badly wrong predictions to grow the accumulator
	task automatic test_long_batch();
		int i;
		logic lbl;
		logic [PRED_W-1:0] pred;
		write_regs(N_W'(400), rand_weight(), FLR_W'(7));
		for (i = 0; i < 400; i++) begin
			lbl = 1'($urandom_range(0, 1));
			pred = lbl ? PRED_W'($urandom_range(0, 2000)) : PRED_W'($urandom_range(63536, 65536));
			send_item(pred, lbl, i == 399);
		end
		stop_and_drain();
	endtask

	task automatic test_random(input int target);
		int sent;
		int b;
		int i;
		int blen;
		sent = 0;
		while (sent < target) begin
			write_regs(rand_samples(), rand_weight(), rand_floor());
			for (b = 0; b < 20 && sent < target; b++) begin
				if ($urandom_range(0, 5) == 0)
					tx_gaps_on = !tx_gaps_on;
				blen = ($urandom_range(0, 15) == 0) ? int'($urandom_range(20, 80))
					: int'($urandom_range(1, 8));
				for (i = 0; i < blen; i++)
					send_item(rand_prediction(), 1'($urandom_range(0, 1)), i == blen - 1);
				sent += blen;
			end
			// sometimes leave a batch open across the register change
			if ($urandom_range(0, 3) == 0) begin
				for (i = 0; i < 3; i++)
					send_item(rand_prediction(), 1'($urandom_range(0, 1)), 1'b0);
				sent += 3;
			end
			stop_and_drain();
		end
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		int gap;
		int hold;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			if ($urandom_range(0, 40) == 0)
				rx_gaps_on = !rx_gaps_on;
			gap = rx_gaps_on ? int'($urandom_range(0, 12)) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		bce_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (grad_loss_q.size() == 0) begin
				$error("unexpected item: gradient %0d", $signed(m_axis_tdata[GRAD_W-1:0]));
				mismatch_count++;
			end else begin
				exp_r = grad_loss_q.pop_front();
				if (m_axis_tdata[GRAD_W-1:0] !== exp_r.gradient) begin
					$error("gradient: expected %0d, actual %0d", exp_r.gradient,
						$signed(m_axis_tdata[GRAD_W-1:0]));
					mismatch_count++;
				end
				if (m_axis_tdata[GRAD_W +: LOSS_W] !== exp_r.batch_loss) begin
					$error("batch_loss: expected %0d, actual %0d", exp_r.batch_loss,
						m_axis_tdata[GRAD_W +: LOSS_W]);
					mismatch_count++;
				end
				if (m_axis_tlast !== exp_r.loss_valid) begin
					$error("loss_valid: expected %0b, actual %0b", exp_r.loss_valid,
						m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SAMPLES;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_long_batch();
		test_random(1150);
		stop_and_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
